// ===== rtl/hpl_pkg.sv =====
// hpl_pkg: shared types, constants and keyword tables for the line parser
// depends on nothing; imported by every module of the block
`default_nettype none

package hpl_pkg;

    // buffer capacities
    localparam int TOKEN_CAP = 16;
    localparam int PARAM_CAP = 32;
    localparam int TOK_W     = $clog2(TOKEN_CAP);
    localparam int PAR_W     = $clog2(PARAM_CAP);

    // parse phases
    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_PARAM = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_OTHER = 3'd1;
    localparam logic [2:0] EV_CONN  = 3'd2;
    localparam logic [2:0] EV_WIFI  = 3'd3;
    localparam logic [2:0] EV_SENT  = 3'd4;
    localparam logic [2:0] EV_RECV  = 3'd5;

    // characters
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_FIVE = 8'h35;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    // keyword ids and text
    localparam int         NUM_KW  = 4;
    localparam logic [1:0] KW_CONN = 2'd0;
    localparam logic [1:0] KW_WIFI = 2'd1;
    localparam logic [1:0] KW_SENT = 2'd2;
    localparam logic [1:0] KW_RECV = 2'd3;

    localparam int KW_CONN_LEN = 10;
    localparam int KW_WIFI_LEN = 4;
    localparam int KW_SENT_LEN = 4;
    localparam int KW_RECV_LEN = 7;

    localparam logic [8*KW_CONN_LEN-1:0] KW_CONN_TXT = "connection";
    localparam logic [8*KW_WIFI_LEN-1:0] KW_WIFI_TXT = "wifi";
    localparam logic [8*KW_SENT_LEN-1:0] KW_SENT_TXT = "sent";
    localparam logic [8*KW_RECV_LEN-1:0] KW_RECV_TXT = "receive";

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic net;
        logic tcp;
        logic sent;
        logic data;
        logic line;
    } status_t;

    // one command from the front to the back
    typedef struct packed {
        logic [2:0]       event_code;
        logic             stream;
        logic [PAR_W-1:0] plen;
        status_t          status;
    } cmd_t;

    // parameter memory write port
    typedef struct packed {
        logic             en;
        logic [PAR_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

    // one result
    typedef struct packed {
        logic [2:0] event_code;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       last;
        status_t    status;
    } res_t;

    function automatic logic [3:0] kw_len(input logic [1:0] k);
        logic [3:0] len;
        len = 4'd0;
        case (k)
            KW_CONN: len = 4'(KW_CONN_LEN);
            KW_WIFI: len = 4'(KW_WIFI_LEN);
            KW_SENT: len = 4'(KW_SENT_LEN);
            KW_RECV: len = 4'(KW_RECV_LEN);
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // character i of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] i);
        logic [7:0] ch;
        ch = CHAR_NUL;
        case (k)
            KW_CONN:
                if (int'(i) < KW_CONN_LEN)
                    ch = KW_CONN_TXT[8*(KW_CONN_LEN-1-int'(i)) +: 8];
            KW_WIFI:
                if (int'(i) < KW_WIFI_LEN)
                    ch = KW_WIFI_TXT[8*(KW_WIFI_LEN-1-int'(i)) +: 8];
            KW_SENT:
                if (int'(i) < KW_SENT_LEN)
                    ch = KW_SENT_TXT[8*(KW_SENT_LEN-1-int'(i)) +: 8];
            KW_RECV:
                if (int'(i) < KW_RECV_LEN)
                    ch = KW_RECV_TXT[8*(KW_RECV_LEN-1-int'(i)) +: 8];
            default:
                ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hpl_front.sv =====
// hpl_front: byte parser, running keyword match and line classification
// depends on hpl_pkg; feeds hpl_queue and the parameter memory in hpl_back
`default_nettype none

module hpl_front
    import hpl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       clear_sent,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd,
    output wr_t             wr,
    input  wire logic       stream_done
);

    logic [1:0]        phase_reg, phase_next;
    logic [TOK_W-1:0]  tok_cnt_reg, tok_cnt_next;
    logic [TOK_W-1:0]  tok_len_reg, tok_len_next;
    logic              tok_zero_reg, tok_zero_next;
    logic              tok_lower_reg, tok_lower_next;
    logic [NUM_KW-1:0] match_reg, match_next;
    logic [PAR_W-1:0]  par_cnt_reg, par_cnt_next;
    logic [PAR_W-1:0]  par_len_reg, par_len_next;
    logic              par_zero_reg, par_zero_next;
    logic              par_five_reg, par_five_next;
    status_t           status_reg, status_next;
    logic              pend_reg, pend_next;

    logic              accept;
    logic              eol;
    logic              finish;
    logic [PAR_W-1:0]  plen_eff;
    logic              five_eff;
    logic [2:0]        ev;
    status_t           st;
    logic [NUM_KW-1:0] hit;
    logic              tok_room;
    logic              par_room;

    assign in_stall = q_full || pend_reg;
    assign accept   = in_valid && !in_stall;
    assign eol      = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign tok_room = ({1'b0, tok_cnt_reg} + 1'b1) < (TOK_W+1)'(TOKEN_CAP);
    assign par_room = ({1'b0, par_cnt_reg} + 1'b1) < (PAR_W+1)'(PARAM_CAP);

    always_comb
    begin
        for (int k = 0; k < NUM_KW; k++)
        begin
            hit[k] = match_reg[k] && (tok_len_reg == TOK_W'(kw_len(2'(k))));
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        tok_cnt_next   = tok_cnt_reg;
        tok_len_next   = tok_len_reg;
        tok_zero_next  = tok_zero_reg;
        tok_lower_next = tok_lower_reg;
        match_next     = match_reg;
        par_cnt_next   = par_cnt_reg;
        par_len_next   = par_len_reg;
        par_zero_next  = par_zero_reg;
        par_five_next  = par_five_reg;
        status_next    = status_reg;
        pend_next      = pend_reg && !stream_done;
        wr             = '0;
        finish         = 1'b0;
        plen_eff       = '0;
        five_eff       = 1'b0;
        ev             = EV_NONE;
        st             = status_reg;

        if (accept)
        begin
            if (clear_sent)
            begin
                st.sent = 1'b0;
            end
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == CHAR_HASH)
                    begin
                        phase_next     = PH_TOKEN;
                        tok_cnt_next   = '0;
                        tok_len_next   = '0;
                        tok_zero_next  = 1'b0;
                        tok_lower_next = 1'b0;
                        match_next     = '1;
                    end
                end
                PH_TOKEN:
                begin
                    if (rx_byte == CHAR_PLUS)
                    begin
                        phase_next    = PH_PARAM;
                        par_cnt_next  = '0;
                        par_len_next  = '0;
                        par_zero_next = 1'b0;
                        par_five_next = 1'b0;
                    end
                    else if (eol)
                    begin
                        // line without parameter: parameter is empty
                        phase_next    = PH_WAIT;
                        par_cnt_next  = '0;
                        par_len_next  = '0;
                        par_zero_next = 1'b0;
                        par_five_next = 1'b0;
                        finish        = 1'b1;
                    end
                    else if (tok_room)
                    begin
                        tok_cnt_next = tok_cnt_reg + 1'b1;
                        if (!tok_zero_reg)
                        begin
                            if (rx_byte == CHAR_NUL)
                            begin
                                tok_zero_next = 1'b1;
                            end
                            else
                            begin
                                tok_len_next = tok_len_reg + 1'b1;
                                if (tok_cnt_reg == '0)
                                begin
                                    tok_lower_next = (rx_byte >= CHAR_LC_A) &&
                                                     (rx_byte <= CHAR_LC_Z);
                                end
                                for (int k = 0; k < NUM_KW; k++)
                                begin
                                    match_next[k] = match_reg[k] &&
                                        (tok_cnt_reg < TOK_W'(kw_len(2'(k)))) &&
                                        (rx_byte == kw_char(2'(k), tok_cnt_reg[3:0]));
                                end
                            end
                        end
                    end
                end
                PH_PARAM:
                begin
                    if (eol)
                    begin
                        phase_next = PH_WAIT;
                        plen_eff   = par_len_reg;
                        five_eff   = par_five_reg;
                        finish     = 1'b1;
                    end
                    else if (par_room)
                    begin
                        wr.en        = 1'b1;
                        wr.addr      = par_cnt_reg;
                        wr.data      = rx_byte;
                        par_cnt_next = par_cnt_reg + 1'b1;
                        if (!par_zero_reg)
                        begin
                            if (rx_byte == CHAR_NUL)
                            begin
                                par_zero_next = 1'b1;
                            end
                            else
                            begin
                                par_len_next = par_len_reg + 1'b1;
                                if (par_cnt_reg == '0)
                                begin
                                    par_five_next = (rx_byte == CHAR_FIVE);
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase

            if (finish)
            begin
                st.line = 1'b1;
                ev      = EV_OTHER;
                if (tok_lower_reg)
                begin
                    if (hit[KW_CONN])
                    begin
                        st.tcp = 1'b1;
                        ev     = EV_CONN;
                    end
                    else if (hit[KW_WIFI])
                    begin
                        if ((plen_eff != '0) && five_eff)
                        begin
                            st.net = 1'b1;
                        end
                        ev = EV_WIFI;
                    end
                    else if (hit[KW_SENT])
                    begin
                        st.sent = 1'b1;
                        ev      = EV_SENT;
                    end
                    else if (hit[KW_RECV])
                    begin
                        st.data = 1'b1;
                        ev      = EV_RECV;
                    end
                end
            end
            status_next = st;
        end

        q_cmd.event_code = ev;
        q_cmd.stream     = (ev == EV_RECV) && (plen_eff != '0);
        q_cmd.plen       = plen_eff;
        q_cmd.status     = st;
        q_push           = accept;

        // hold input until the memory has been streamed out
        if (accept && q_cmd.stream)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            tok_cnt_reg   <= '0;
            tok_len_reg   <= '0;
            tok_zero_reg  <= 1'b0;
            tok_lower_reg <= 1'b0;
            match_reg     <= '0;
            par_cnt_reg   <= '0;
            par_len_reg   <= '0;
            par_zero_reg  <= 1'b0;
            par_five_reg  <= 1'b0;
            status_reg    <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tok_cnt_reg   <= tok_cnt_next;
            tok_len_reg   <= tok_len_next;
            tok_zero_reg  <= tok_zero_next;
            tok_lower_reg <= tok_lower_next;
            match_reg     <= match_next;
            par_cnt_reg   <= par_cnt_next;
            par_len_reg   <= par_len_next;
            par_zero_reg  <= par_zero_next;
            par_five_reg  <= par_five_next;
            status_reg    <= status_next;
            pend_reg      <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hpl_queue.sv =====
// hpl_queue: short command fifo between the parser and the result stage
// depends on hpl_pkg for cmd_t and the depth
`default_nettype none

module hpl_queue
    import hpl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      q_valid,
    output cmd_t      q_cmd
);

    cmd_t              buf_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = buf_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hpl_back.sv =====
// hpl_back: parameter memory, payload streaming and the output register
// depends on hpl_pkg; takes commands from hpl_queue and writes from hpl_front
`default_nettype none

module hpl_back
    import hpl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    input  wr_t       wr,
    output logic      stream_done,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_t      res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;

    logic [7:0]       mem [PARAM_CAP];
    logic [7:0]       rd_data_reg;

    logic [1:0]       state_reg, state_next;
    logic [PAR_W-1:0] idx_reg, idx_next;
    logic [PAR_W-1:0] plen_reg, plen_next;
    status_t          cur_st_reg, cur_st_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;
    logic             out_free;
    logic             is_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_last   = ({1'b0, idx_reg} + 1'b1) == {1'b0, plen_reg};
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        plen_next      = plen_reg;
        cur_st_next    = cur_st_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        stream_done    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.stream)
                    begin
                        idx_next    = '0;
                        plen_next   = q_cmd.plen;
                        cur_st_next = q_cmd.status;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        res_next.event_code    = q_cmd.event_code;
                        res_next.payload_byte  = 8'h00;
                        res_next.payload_valid = 1'b0;
                        res_next.last          = 1'b1;
                        res_next.status        = q_cmd.status;
                        out_valid_next         = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    res_next.event_code    = EV_RECV;
                    res_next.payload_byte  = rd_data_reg;
                    res_next.payload_valid = 1'b1;
                    res_next.last          = is_last;
                    res_next.status        = cur_st_reg;
                    out_valid_next         = 1'b1;
                    if (is_last)
                    begin
                        state_next  = ST_IDLE;
                        stream_done = 1'b1;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        idx_reg    <= idx_next;
        plen_reg   <= plen_next;
        cur_st_reg <= cur_st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hash_token_plus_param_line_parser.sv =====
// hash_token_plus_param_line_parser: top level of the '#token+param' line parser
// depends on hpl_pkg, hpl_front, hpl_queue and hpl_back
`default_nettype none

//  channel   direction  handshake              payload
//  ------    ---------  ---------------------  -------------------------------------------
//  in        request    in_valid / in_stall    rx_byte, clear_sent
//  out       result     out_valid / out_stall  event_code, payload_byte, payload_valid,
//                                              last, network_up, tcp_up, sent_seen,
//                                              data_seen, line_ready
//
//  one request per cycle while the two-entry command queue has room; each request
//  makes one result, except a receive line with n parameter bytes, which makes n
//  results, each through the registered read of the parameter memory,
//  and holds the input stalled until the last of them is loaded
//  reset clears the parse phase, counters, flags, queue and output valid; the
//  parameter memory is not cleared, entries past the stored count are never read
//  either side may stall at any time; the output register parts the two sides

module hash_token_plus_param_line_parser
    import hpl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    // request channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       clear_sent,

    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      event_code,
    output logic [7:0]      payload_byte,
    output logic            payload_valid,
    output logic            last,
    output logic            network_up,
    output logic            tcp_up,
    output logic            sent_seen,
    output logic            data_seen,
    output logic            line_ready
);

    // front to queue
    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;

    // queue to back
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // parameter memory writes and stream completion
    wr_t  wr;
    logic stream_done;

    res_t res;

    // parser: phase tracking, keyword match as bytes arrive, flag update
    hpl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .clear_sent  (clear_sent),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd),
        .wr          (wr),
        .stream_done (stream_done)
    );

    // decouples parsing from result delivery
    hpl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // result stage: single results or payload runs from the parameter memory
    hpl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .wr          (wr),
        .stream_done (stream_done),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res         (res)
    );

    // break the result register out onto the ports
    assign event_code    = res.event_code;
    assign payload_byte  = res.payload_byte;
    assign payload_valid = res.payload_valid;
    assign last          = res.last;
    assign network_up    = res.status.net;
    assign tcp_up        = res.status.tcp;
    assign sent_seen     = res.status.sent;
    assign data_seen     = res.status.data;
    assign line_ready    = res.status.line;

endmodule

`default_nettype wire
